### src/esd_pkg.sv
// Shared types, character codes and helper functions for the escape sequence decoder.
package esd_pkg;

    // Parse phase of the front end.
    typedef enum logic [1:0] {
        PH_LIT  = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX1 = 2'd2,
        PH_HEX2 = 2'd3
    } esd_phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } esd_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } esd_out_t;

    // One queue entry: the one or two words that one input word produces.
    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
        logic       last;
    } esd_cmd_t;

    localparam int ESD_QDEPTH = 4;
    localparam int ESD_QAW    = $clog2(ESD_QDEPTH);
    localparam int ESD_QCW    = $clog2(ESD_QDEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] CTL_BEL = 8'h07;
    localparam logic [7:0] CTL_BS  = 8'h08;
    localparam logic [7:0] CTL_FF  = 8'h0C;
    localparam logic [7:0] CTL_LF  = 8'h0A;
    localparam logic [7:0] CTL_CR  = 8'h0D;
    localparam logic [7:0] CTL_HT  = 8'h09;
    localparam logic [7:0] CTL_VT  = 8'h0B;

    // Hex digit value; anything that is not a hex digit counts as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'h00;
            if (c >= CH_0 && c <= CH_9)
            begin
                d = c - CH_0;
            end
            else if (c >= CH_A && c <= CH_F)
            begin
                d = c - CH_A + 8'd10;
            end
            else if (c >= CH_UA && c <= CH_UF)
            begin
                d = c - CH_UA + 8'd10;
            end
            return d[3:0];
        end
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] c);
        logic [7:0] r;
        begin
            unique case (c)
                CH_A:    r = CTL_BEL;
                CH_B:    r = CTL_BS;
                CH_F:    r = CTL_FF;
                CH_N:    r = CTL_LF;
                CH_R:    r = CTL_CR;
                CH_T:    r = CTL_HT;
                CH_V:    r = CTL_VT;
                default: r = c;
            endcase
            return r;
        end
    endfunction

endpackage

### src/esd_front.sv
// Front end: accepts raw words, tracks the escape phase and builds queue entries.
module esd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  esd_pkg::esd_in_t  item,
    output logic              cmd_valid,
    output esd_pkg::esd_cmd_t cmd
);

    esd_pkg::esd_phase_t phase_reg;
    esd_pkg::esd_phase_t phase_next;
    logic [7:0]          held_reg;
    logic [7:0]          held_next;

    logic [7:0] b;
    logic       last;

    assign b    = item.in_byte;
    assign last = item.in_last;

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        if (accept)
        begin
            unique case (phase_reg)
                esd_pkg::PH_LIT:
                begin
                    if (b == esd_pkg::CH_BSLASH)
                    begin
                        phase_next = esd_pkg::PH_ESC;
                    end
                end
                esd_pkg::PH_ESC:
                begin
                    phase_next = (b == esd_pkg::CH_X) ? esd_pkg::PH_HEX1 : esd_pkg::PH_LIT;
                end
                esd_pkg::PH_HEX1:
                begin
                    held_next  = b;
                    phase_next = esd_pkg::PH_HEX2;
                end
                esd_pkg::PH_HEX2:
                begin
                    held_next  = 8'h00;
                    phase_next = esd_pkg::PH_LIT;
                end
                default:
                begin
                    phase_next = esd_pkg::PH_LIT;
                end
            endcase
            // end of string always restarts clean
            if (last)
            begin
                phase_next = esd_pkg::PH_LIT;
                held_next  = 8'h00;
            end
        end
    end

    // Outputs.
    always_comb
    begin
        cmd_valid  = 1'b0;
        cmd.two    = 1'b0;
        cmd.first  = b;
        cmd.second = esd_pkg::CH_NUL;
        cmd.last   = last;
        unique case (phase_reg)
            esd_pkg::PH_LIT:
            begin
                if (b == esd_pkg::CH_BSLASH)
                begin
                    cmd_valid = last;
                    cmd.first = esd_pkg::CH_NUL;
                end
                else
                begin
                    cmd_valid = 1'b1;
                end
            end
            esd_pkg::PH_ESC:
            begin
                cmd_valid = !(b == esd_pkg::CH_X && !last);
                cmd.first = esd_pkg::map_escape(b);
            end
            esd_pkg::PH_HEX1:
            begin
                // string ends after \x and one byte: 'x' then that byte as a literal, a backslash as 0x00
                cmd_valid  = last;
                cmd.two    = 1'b1;
                cmd.first  = esd_pkg::CH_X;
                cmd.second = (b == esd_pkg::CH_BSLASH) ? esd_pkg::CH_NUL : b;
            end
            esd_pkg::PH_HEX2:
            begin
                cmd_valid = 1'b1;
                cmd.first = {esd_pkg::hex_value(held_reg), esd_pkg::hex_value(b)};
            end
            default:
            begin
                cmd_valid = 1'b0;
            end
        endcase
        cmd_valid = cmd_valid && accept;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= esd_pkg::PH_LIT;
            held_reg  <= 8'h00;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

### src/esd_fifo.sv
// Short entry queue between the front end and the output stage.
module esd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  esd_pkg::esd_cmd_t wr_data,
    input  logic              rd_en,
    output esd_pkg::esd_cmd_t rd_data,
    output logic              q_full,
    output logic              q_empty
);

    esd_pkg::esd_cmd_t                 mem_reg [esd_pkg::ESD_QDEPTH];
    logic [esd_pkg::ESD_QAW-1:0]       wr_ptr_reg;
    logic [esd_pkg::ESD_QAW-1:0]       wr_ptr_next;
    logic [esd_pkg::ESD_QAW-1:0]       rd_ptr_reg;
    logic [esd_pkg::ESD_QAW-1:0]       rd_ptr_next;
    logic [esd_pkg::ESD_QCW-1:0]       count_reg;
    logic [esd_pkg::ESD_QCW-1:0]       count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign q_full  = (count_reg == esd_pkg::ESD_QCW'(esd_pkg::ESD_QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointers wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == esd_pkg::ESD_QAW'(esd_pkg::ESD_QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == esd_pkg::ESD_QAW'(esd_pkg::ESD_QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= esd_pkg::ESD_QCW'(esd_pkg::ESD_QDEPTH))
        else $error("queue count beyond depth");

    a_no_lost_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("entry written into a full queue");

endmodule

### src/esd_back.sv
// Output stage: takes queue entries and hands out their words one at a time.
module esd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  esd_pkg::esd_cmd_t q_data,
    input  logic              q_empty,
    output logic              q_rd,
    input  logic              pop,
    output logic              empty,
    output esd_pkg::esd_out_t result
);

    esd_pkg::esd_cmd_t entry_reg;
    logic              have_reg;
    logic              have_next;
    logic              second_reg;
    logic              second_next;
    logic              take;
    logic              finish;
    logic              shift;

    assign empty  = !have_reg;
    assign finish = !entry_reg.two || second_reg;
    assign shift  = pop && have_reg;
    assign take   = !q_empty && (!have_reg || (shift && finish));
    assign q_rd   = take;

    assign result.out_byte = second_reg ? entry_reg.second : entry_reg.first;
    assign result.out_last = entry_reg.last && finish;

    always_comb
    begin
        have_next   = have_reg;
        second_next = second_reg;
        if (take)
        begin
            have_next   = 1'b1;
            second_next = 1'b0;
        end
        else if (shift && finish)
        begin
            have_next   = 1'b0;
            second_next = 1'b0;
        end
        else if (shift)
        begin
            second_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg <= q_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg   <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            have_reg   <= have_next;
            second_reg <= second_next;
        end
    end

    a_first_of_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (have_reg && entry_reg.two && !second_reg) |-> !result.out_last)
        else $error("first word of a pair marked last");

    a_pair_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (shift && entry_reg.two && !second_reg) |=> (!empty && second_reg))
        else $error("second word of a pair dropped");

endmodule

### src/escape_sequence_decoder.sv
// Top level of the escape sequence decoder: front end, entry queue and output stage.
//
// Decodes a C-style escaped string arriving one raw byte per word, with a
// last flag on the final byte. Plain bytes pass through; a backslash starts
// an escape (a b f n r t v become control codes, anything else is itself);
// \x plus two bytes gives one byte from two hex digits, a non-hex digit
// counting as zero. A string that ends inside an escape is flushed: a lone
// trailing backslash gives 0x00, \x at the end gives 'x', and \x with one
// byte at the end gives 'x' then that byte (0x00 for a backslash). Every
// string's final result word carries out_last. Both sides are queues: the
// input takes one word per clock whenever full is low, and the output hands
// one word per clock while empty is low and pop is high. The front end
// decodes in the cycle a word is accepted and writes at most one entry (one
// or two result words) into a four-entry queue; the output stage loads the
// next entry as it retires the current one, so a result word passes through
// the queue and the output stage's entry register. full rises only when the
// queue fills, which happens only when pop is held low; \x with one byte at
// the end produces two words from one input, the single case that can
// briefly run the output side below the input side.
module escape_sequence_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  esd_pkg::esd_in_t  item,
    output logic              empty,
    input  logic              pop,
    output esd_pkg::esd_out_t result
);

    logic              accept;
    logic              cmd_valid;
    esd_pkg::esd_cmd_t cmd;
    esd_pkg::esd_cmd_t q_data;
    logic              q_full;
    logic              q_empty;
    logic              q_rd;

    // input word taken whenever the queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    esd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    esd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    esd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_empty (q_empty),
        .q_rd    (q_rd),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // a final input word always yields at least one result word
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.in_last) |-> cmd_valid)
        else $error("final word produced no result");

endmodule

### bench/tb_escape_sequence_decoder.sv
// Testbench for escape_sequence_decoder: directed and random escaped strings against a scoreboard.
`timescale 1ns / 100ps

module tb_escape_sequence_decoder;
    import esd_pkg::*;

    // Generous cycle limit. The slowest correct run is about 1000 words,
    // up to two results each, every one waiting out a long receiver stall,
    // plus the sender's gaps.
    localparam int unsigned LIMIT = 200000;

    // Holds the decoder's expected output words and predicts them from the
    // accepted input words. It keeps its own copy of the parse state.
    class esd_scoreboard;
        esd_phase_t phase;
        logic [7:0] held;
        esd_out_t   want_q[$];
        int         errors;

        function new();
            phase  = PH_LIT;
            held   = 8'h00;
            errors = 0;
        endfunction

        // Hex digit value. Anything outside 0-9, a-f and A-F counts as zero.
        function logic [3:0] digit(logic [7:0] c);
            if (c inside {[CH_0:CH_9]})
                return c[3:0];
            if (c inside {[CH_A:CH_F], [CH_UA:CH_UF]})
                return c[3:0] + 4'd9;
            return 4'd0;
        endfunction

        function logic [7:0] control_code(logic [7:0] c);
            case (c)
                CH_A:    return CTL_BEL;
                CH_B:    return CTL_BS;
                CH_F:    return CTL_FF;
                CH_N:    return CTL_LF;
                CH_R:    return CTL_CR;
                CH_T:    return CTL_HT;
                CH_V:    return CTL_VT;
                default: return c;
            endcase
        endfunction

        function void queue_word(logic [7:0] b, logic fin);
            esd_out_t w;
            w.out_byte = b;
            w.out_last = fin;
            want_q.push_back(w);
        endfunction

        // Called once per accepted input word.
        function void note(esd_in_t w);
            logic [7:0] b;
            logic       fin;
            b   = w.in_byte;
            fin = w.in_last;
            case (phase)
                PH_LIT:
                begin
                    if (b == CH_BSLASH)
                    begin
                        if (fin)
                            queue_word(CH_NUL, 1'b1);
                        else
                            phase = PH_ESC;
                    end
                    else
                        queue_word(b, fin);
                end
                PH_ESC:
                begin
                    if (b == CH_X && !fin)
                        phase = PH_HEX1;
                    else
                    begin
                        queue_word(control_code(b), fin);
                        phase = PH_LIT;
                    end
                end
                PH_HEX1:
                begin
                    if (fin)
                    begin
                        // String ended one byte into \x: 'x', then the byte as a literal.
                        queue_word(CH_X, 1'b0);
                        queue_word((b == CH_BSLASH) ? CH_NUL : b, 1'b1);
                        phase = PH_LIT;
                    end
                    else
                    begin
                        held  = b;
                        phase = PH_HEX2;
                    end
                end
                default:
                begin
                    queue_word({digit(held), digit(b)}, fin);
                    held  = 8'h00;
                    phase = PH_LIT;
                end
            endcase
            if (fin)
            begin
                phase = PH_LIT;
                held  = 8'h00;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Called once per accepted output word.
        task check(esd_out_t got);
            esd_out_t want;
            if (want_q.size() == 0)
                report($sformatf("unexpected word %02h last %0b", got.out_byte, got.out_last));
            else
            begin
                want = want_q.pop_front();
                if (got.out_byte != want.out_byte)
                    report($sformatf("out_byte %02h, expected %02h",
                                     got.out_byte, want.out_byte));
                if (got.out_last != want.out_last)
                    report($sformatf("out_last %0b, expected %0b (byte %02h)",
                                     got.out_last, want.out_last, want.out_byte));
            end
        endtask

        function int pending();
            return want_q.size();
        endfunction
    endclass

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        push  = 1'b0;
    logic        pop   = 1'b0;
    logic        full;
    logic        empty;
    esd_in_t     item  = '0;
    esd_out_t    result;

    int unsigned cycles = 0;
    int          stall  = 0;
    esd_scoreboard sb;

    // Whole stimulus, built up front: one entry per input word.
    esd_in_t words[$];

    escape_sequence_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always #1 clk = ~clk;

    // Cycle count and timeout.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
            $display("tb_escape_sequence_decoder NOT OK");
            $finish;
        end
    end

    // Monitor: both handshakes are sampled at the edge. Inputs change only
    // through nonblocking assignments, so this sees the pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note(item);
            if (pop && !empty)
                sb.check(result);
        end
    end

    // Receiver: the stall pattern is picked from bits 9:8 of the cycle count.
    // It pops freely, pops at random, pops when the cycle count is a multiple
    // of seven, or pops with occasional long stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            case ((cycles >> 8) % 4)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 1);
                2: pop <= (cycles % 7 == 0);
                default:
                begin
                    if (stall > 0)
                    begin
                        stall <= stall - 1;
                        pop   <= 1'b0;
                    end
                    else
                    begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 15) == 0)
                            stall <= $urandom_range(5, 20);
                    end
                end
            endcase
        end
    end

    task add(logic [7:0] b, logic fin);
        esd_in_t w;
        w.in_byte = b;
        w.in_last = fin;
        words.push_back(w);
    endtask

    // A hex digit character, now and then a near miss just outside a range or a random byte.
    function logic [7:0] hex_char();
        case ($urandom_range(0, 5))
            0, 1: return CH_0 + 8'($urandom_range(0, 9));
            2:    return CH_A + 8'($urandom_range(0, 5));
            3:    return CH_UA + 8'($urandom_range(0, 5));
            4:
            begin
                case ($urandom_range(0, 5))
                    0:       return 8'h2F;
                    1:       return 8'h3A;
                    2:       return 8'h40;
                    3:       return 8'h47;
                    4:       return 8'h60;
                    default: return 8'h67;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function logic [7:0] escape_letter();
        case ($urandom_range(0, 6))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_F;
            3:       return CH_N;
            4:       return CH_R;
            5:       return CH_T;
            default: return CH_V;
        endcase
    endfunction

    // One random string. Most are well formed: plain bytes, letter escapes,
    // other escapes, hex escapes, escaped backslashes. Some end inside an
    // escape, and one in eight is noise heavy in backslashes and x's.
    task gen_string();
        logic [7:0] s[$];
        logic [7:0] b;
        int         n;
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        if ($urandom_range(0, 7) == 0)
        begin
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       s.push_back(CH_BSLASH);
                    1:       s.push_back(CH_X);
                    default: s.push_back(8'($urandom));
                endcase
            end
        end
        else
        begin
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        do
                            b = 8'($urandom);
                        while (b == CH_BSLASH);
                        s.push_back(b);
                    end
                    4, 5:
                    begin
                        s.push_back(CH_BSLASH);
                        s.push_back(escape_letter());
                    end
                    6:
                    begin
                        b = 8'($urandom);
                        s.push_back(CH_BSLASH);
                        s.push_back((b == CH_X) ? 8'h58 : b);
                    end
                    7, 8:
                    begin
                        s.push_back(CH_BSLASH);
                        s.push_back(CH_X);
                        s.push_back(hex_char());
                        s.push_back(hex_char());
                    end
                    default:
                    begin
                        s.push_back(CH_BSLASH);
                        s.push_back(CH_BSLASH);
                    end
                endcase
            end
            // Broken endings: string stops inside an escape.
            case ($urandom_range(0, 11))
                0: s.push_back(CH_BSLASH);
                1:
                begin
                    s.push_back(CH_BSLASH);
                    s.push_back(CH_X);
                end
                2:
                begin
                    s.push_back(CH_BSLASH);
                    s.push_back(CH_X);
                    s.push_back(($urandom_range(0, 2) == 0) ? CH_BSLASH : 8'($urandom));
                end
                default: ;
            endcase
        end
        foreach (s[i])
            add(s[i], i == s.size() - 1);
    endtask

    // Drive one word and hold it until the block takes it. Called right
    // after a rising edge; returns right after the edge that accepted it.
    task send_word(esd_in_t w);
        push <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (full);
    endtask

    task gap(int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every expected word has come out.
    task drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [7:0] letters[7];
        int         idx;
        int         burst;

        sb = new();
        letters = '{CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V};

        // Directed strings.
        add(CH_NUL, 1'b0);              // zero byte is an ordinary byte
        add(8'hFF, 1'b1);
        foreach (letters[i])
        begin
            add(CH_BSLASH, 1'b0);
            add(letters[i], i == 6);
        end
        add(CH_BSLASH, 1'b0);           // uppercase X is not a hex escape
        add(8'h58, 1'b1);
        add(CH_BSLASH, 1'b0);           // hex escape, high digit upper case, low digit non-hex
        add(CH_X, 1'b0);
        add(8'h41, 1'b0);
        add(8'h67, 1'b1);
        add(CH_BSLASH, 1'b1);           // lone trailing backslash
        add(CH_BSLASH, 1'b0);           // \x at the end
        add(CH_X, 1'b1);
        add(CH_BSLASH, 1'b0);           // \x plus one byte, that byte a backslash
        add(CH_X, 1'b0);
        add(CH_BSLASH, 1'b1);

        while (words.size() < 980)
            gen_string();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bursts of random length with random gaps; about a quarter of
        // the gaps are zero, so long stretches run back to back.
        idx = 0;
        while (idx < words.size())
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && idx < words.size())
            begin
                send_word(words[idx]);
                idx++;
                burst--;
                // Let the block run dry a few times mid-stream.
                if (idx % 300 == 0)
                    drain();
            end
            gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
        end

        drain();
        repeat (16) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_escape_sequence_decoder OK");
        else
            $display("tb_escape_sequence_decoder NOT OK");
        $finish;
    end

endmodule
